// ----- design/ksrp_pkg.sv -----
// Package: payload types, operand tables and rounding helpers for the keyframe selector.
package ksrp_pkg;

	localparam int AccW = 68;
	localparam logic signed [15:0] RotOne = 16'sd16384;

	typedef struct packed {
		logic signed [31:0] frame_id;
		logic [47:0] stamp_us;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} pose_t;

	typedef struct packed {
		logic accepted;
		logic signed [31:0] result_id;
		logic [1:0] row_index;
		logic signed [15:0] rot_col0;
		logic signed [15:0] rot_col1;
		logic signed [15:0] rot_col2;
		logic signed [31:0] trans_part;
		logic last_row;
	} row_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_MIN_TIME = 1'b0,
		REG_MIN_DIST = 1'b1
	} reg_idx_t;

	// Quaternion component selects.
	typedef enum logic [1:0] {
		Q_W = 2'd0,
		Q_X = 2'd1,
		Q_Y = 2'd2,
		Q_Z = 2'd3
	} qsel_t;

	typedef struct packed {
		qsel_t ia;
		qsel_t ib;
		logic neg;
	} qterm_t;

	// Row/column split of a relative rotation entry.
	typedef struct packed {
		logic [1:0] r;
		logic [1:0] c;
	} rc_t;

	// Product terms of the quaternion to rotation matrix formula (each doubled).
	function automatic qterm_t quat_term(input logic [3:0] g, input logic k);
		qterm_t t;
		t = '{ia: Q_W, ib: Q_W, neg: 1'b0};
		case ({g, k})
			5'b0000_0: t = '{ia: Q_Y, ib: Q_Y, neg: 1'b1};
			5'b0000_1: t = '{ia: Q_Z, ib: Q_Z, neg: 1'b1};
			5'b0001_0: t = '{ia: Q_X, ib: Q_Y, neg: 1'b0};
			5'b0001_1: t = '{ia: Q_W, ib: Q_Z, neg: 1'b1};
			5'b0010_0: t = '{ia: Q_X, ib: Q_Z, neg: 1'b0};
			5'b0010_1: t = '{ia: Q_W, ib: Q_Y, neg: 1'b0};
			5'b0011_0: t = '{ia: Q_X, ib: Q_Y, neg: 1'b0};
			5'b0011_1: t = '{ia: Q_W, ib: Q_Z, neg: 1'b0};
			5'b0100_0: t = '{ia: Q_X, ib: Q_X, neg: 1'b1};
			5'b0100_1: t = '{ia: Q_Z, ib: Q_Z, neg: 1'b1};
			5'b0101_0: t = '{ia: Q_Y, ib: Q_Z, neg: 1'b0};
			5'b0101_1: t = '{ia: Q_W, ib: Q_X, neg: 1'b1};
			5'b0110_0: t = '{ia: Q_X, ib: Q_Z, neg: 1'b0};
			5'b0110_1: t = '{ia: Q_W, ib: Q_Y, neg: 1'b1};
			5'b0111_0: t = '{ia: Q_Y, ib: Q_Z, neg: 1'b0};
			5'b0111_1: t = '{ia: Q_W, ib: Q_X, neg: 1'b0};
			5'b1000_0: t = '{ia: Q_X, ib: Q_X, neg: 1'b1};
			5'b1000_1: t = '{ia: Q_Y, ib: Q_Y, neg: 1'b1};
			default: t = '{ia: Q_W, ib: Q_W, neg: 1'b0};
		endcase
		return t;
	endfunction

	// Split an entry number 0..8 into its row and column.
	function automatic rc_t split_rc(input logic [3:0] g);
		rc_t v;
		case (g)
			4'd0: v = '{r: 2'd0, c: 2'd0};
			4'd1: v = '{r: 2'd0, c: 2'd1};
			4'd2: v = '{r: 2'd0, c: 2'd2};
			4'd3: v = '{r: 2'd1, c: 2'd0};
			4'd4: v = '{r: 2'd1, c: 2'd1};
			4'd5: v = '{r: 2'd1, c: 2'd2};
			4'd6: v = '{r: 2'd2, c: 2'd0};
			4'd7: v = '{r: 2'd2, c: 2'd1};
			4'd8: v = '{r: 2'd2, c: 2'd2};
			default: v = '{r: 2'd0, c: 2'd0};
		endcase
		return v;
	endfunction

	// Row-major entry number of a 3x3 matrix.
	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'({r, 1'b0} + {2'b00, r} + {2'b00, c});
	endfunction

	// Round half up by 14 bits.
	function automatic logic signed [AccW-1:0] round14(input logic signed [AccW-1:0] v);
		return (v + AccW'(8192)) >>> 14;
	endfunction

	function automatic logic signed [15:0] sat_rot(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] r;
		r = round14(v);
		if (r > AccW'(16384))
			return RotOne;
		else if (r < -AccW'(16384))
			return -RotOne;
		return r[15:0];
	endfunction

	function automatic logic signed [31:0] sat_w32(input logic signed [AccW-1:0] v);
		logic signed [AccW-1:0] r;
		r = round14(v);
		if (r > AccW'(64'sh7FFF_FFFF))
			return 32'sh7FFF_FFFF;
		else if (r < -AccW'(64'sh8000_0000))
			return 32'sh8000_0000;
		return r[31:0];
	endfunction

endpackage

// ----- design/ksrp_if.sv -----
// Interfaces: valid/ready channels for pose items and result rows.
interface ksrp_pose_if;
	logic valid;
	logic ready;
	ksrp_pkg::pose_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ksrp_row_if;
	logic valid;
	logic ready;
	ksrp_pkg::row_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/keyframe_select_relative_pose_core.sv -----
// Top level: keyframe selection with relative rigid pose rows, bit-serial datapath.
//
//  channel  | dir | handshake        | payload
//  pose     | in  | valid/ready      | ksrp_pkg::pose_t, one pose per item
//  result   | out | valid/ready      | ksrp_pkg::row_t, one or three rows per pose
//  wr_*     | in  | wr_en, no wait   | wr_index selects register, wr_data 32 bits
//
// One pose at a time. Each product runs on a shared shift-add multiplier, one
// multiplier bit per cycle, ending early when the remaining bits are zero. A
// pose takes four products for the distance, two per rotation entry (18) and
// three per relative transform entry (36). Rows then go out one per item.
// Reset (arst_n low) clears the keyframe and both registers. Pose ready is low
// from acceptance until the last row is taken; result stalls hold the row.
module keyframe_select_relative_pose_core (
	input logic clk,
	input logic arst_n,
	ksrp_pose_if.sink pose,
	ksrp_row_if.source result,
	input logic wr_en,
	input logic wr_index,
	input logic [31:0] wr_data
);
	import ksrp_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_TIME = 6'b000010,
		ST_DIST = 6'b000100,
		ST_QROT = 6'b001000,
		ST_REL  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t state_q;
	logic [31:0] min_time_q;
	logic [30:0] min_dist_q;

	logic have_kf_q;
	logic [47:0] key_stamp_q;
	logic signed [31:0] key_pos_q [3];
	logic signed [15:0] key_rot_q [9];

	logic signed [31:0] id_q;
	logic [47:0] stamp_q;
	logic signed [31:0] pos_q [3];
	logic signed [15:0] quat_q [4];
	logic signed [32:0] d_q [3];

	logic signed [15:0] rc_q [9];
	logic signed [15:0] rel_q [9];
	logic signed [31:0] tr_q [3];
	logic ok_q;
	logic [1:0] row_q;

	// Serial multiply-accumulate state.
	logic [3:0] g_q;
	logic [2:0] k_q;
	logic busy_q;
	logic sub_q;
	logic [65:0] a_sh_q;
	logic [31:0] b_sh_q;
	logic signed [AccW-1:0] acc_q;

	// Operand selection for the current term.
	logic signed [33:0] op_a;
	logic signed [33:0] op_b;
	logic op_neg;
	logic [1:0] n_terms;
	logic [3:0] last_g;
	qterm_t qt;
	rc_t rcs;
	logic [1:0] ti;
	logic [33:0] a_abs;
	logic [33:0] b_abs;

	always_comb begin
		qt = quat_term(g_q, k_q[0]);
		rcs = split_rc(g_q);
		ti = 2'(g_q - 4'd9);
		op_a = '0;
		op_b = '0;
		op_neg = 1'b0;
		n_terms = 2'd3;
		last_g = 4'd11;
		case (state_q)
			ST_DIST: begin
				last_g = 4'd0;
				n_terms = 2'd3;
				if (k_q == 3'd3) begin
					op_a = 34'(min_dist_q);
					op_b = 34'(min_dist_q);
					op_neg = 1'b1;
				end else begin
					op_a = 34'(d_q[k_q[1:0]]);
					op_b = 34'(d_q[k_q[1:0]]);
				end
			end
			ST_QROT: begin
				last_g = 4'd8;
				n_terms = 2'd1;
				op_a = 34'(quat_q[qt.ia]) <<< 1;
				op_b = 34'(quat_q[qt.ib]);
				op_neg = qt.neg;
			end
			ST_REL: begin
				last_g = 4'd11;
				n_terms = 2'd2;
				if (g_q < 4'd9) begin
					op_a = 34'(key_rot_q[idx3(k_q[1:0], rcs.r)]);
					op_b = 34'(rc_q[idx3(k_q[1:0], rcs.c)]);
				end else begin
					op_a = 34'(d_q[k_q[1:0]]);
					op_b = 34'(key_rot_q[idx3(k_q[1:0], ti)]);
				end
			end
			default: begin
				op_a = '0;
			end
		endcase
		a_abs = op_a[33] ? 34'(-op_a) : 34'(op_a);
		b_abs = op_b[33] ? 34'(-op_b) : 34'(op_b);
	end

	logic signed [AccW-1:0] addend;
	assign addend = sub_q ? -$signed({2'b00, a_sh_q}) : $signed({2'b00, a_sh_q});

	// Accumulator start value for a group: one in Q4.28 on the rotation diagonal.
	function automatic logic signed [AccW-1:0] acc_init(input state_t s, input logic [3:0] g);
		if (s == ST_QROT && (g == 4'd0 || g == 4'd4 || g == 4'd8))
			return AccW'(64'sd268435456);
		return '0;
	endfunction

	logic signed [48:0] dt;
	assign dt = $signed({1'b0, stamp_q}) - $signed({1'b0, key_stamp_q});

	assign pose.ready = (state_q == ST_IDLE);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_time_q <= '0;
			min_dist_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_MIN_TIME: min_time_q <= wr_data;
				REG_MIN_DIST: min_dist_q <= wr_data[30:0];
				default: min_time_q <= min_time_q;
			endcase
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (pose.valid && pose.ready) begin
			id_q <= pose.data.frame_id;
			stamp_q <= pose.data.stamp_us;
			pos_q[0] <= pose.data.pos_x;
			pos_q[1] <= pose.data.pos_y;
			pos_q[2] <= pose.data.pos_z;
			quat_q[Q_W] <= pose.data.quat_w;
			quat_q[Q_X] <= pose.data.quat_x;
			quat_q[Q_Y] <= pose.data.quat_y;
			quat_q[Q_Z] <= pose.data.quat_z;
			d_q[0] <= 33'(pose.data.pos_x) - 33'(key_pos_q[0]);
			d_q[1] <= 33'(pose.data.pos_y) - 33'(key_pos_q[1]);
			d_q[2] <= 33'(pose.data.pos_z) - 33'(key_pos_q[2]);
		end
	end

	// Sequencer and serial multiply-accumulate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_kf_q <= 1'b0;
			key_stamp_q <= '0;
			for (int i = 0; i < 3; i++) key_pos_q[i] <= '0;
			for (int i = 0; i < 9; i++) key_rot_q[i] <= '0;
			g_q <= '0;
			k_q <= '0;
			busy_q <= 1'b0;
			ok_q <= 1'b0;
			row_q <= '0;
			acc_q <= '0;
			sub_q <= 1'b0;
			a_sh_q <= '0;
			b_sh_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pose.valid) begin
						state_q <= ST_TIME;
					end
				end
				ST_TIME: begin
					g_q <= '0;
					k_q <= '0;
					busy_q <= 1'b0;
					row_q <= '0;
					if (!have_kf_q) begin
						ok_q <= 1'b1;
						acc_q <= acc_init(ST_QROT, 4'd0);
						state_q <= ST_QROT;
					end else if (dt < $signed({17'b0, min_time_q})) begin
						ok_q <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						acc_q <= '0;
						state_q <= ST_DIST;
					end
				end
				ST_DIST, ST_QROT, ST_REL: begin
					if (busy_q) begin
						// One multiplier bit per cycle.
						if (b_sh_q[0]) acc_q <= acc_q + addend;
						a_sh_q <= a_sh_q << 1;
						b_sh_q <= b_sh_q >> 1;
						if (b_sh_q[31:1] == '0) begin
							busy_q <= 1'b0;
							k_q <= k_q + 3'd1;
						end
					end else if (k_q <= {1'b0, n_terms}) begin
						a_sh_q <= 66'(a_abs[32:0]);
						b_sh_q <= b_abs[31:0];
						sub_q <= op_a[33] ^ op_b[33] ^ op_neg;
						busy_q <= 1'b1;
					end else begin
						// Group complete: store the result, except in the distance state.
						k_q <= '0;
						g_q <= g_q + 4'd1;
						acc_q <= acc_init(state_q, g_q + 4'd1);
						if (state_q == ST_QROT) begin
							rc_q[g_q] <= sat_rot(acc_q);
						end else if (state_q == ST_REL) begin
							if (g_q < 4'd9)
								rel_q[g_q] <= sat_rot(acc_q);
							else
								tr_q[ti] <= sat_w32(acc_q);
						end
						if (g_q == last_g) begin
							g_q <= '0;
							case (state_q)
								ST_DIST: begin
									ok_q <= !acc_q[AccW-1];
									acc_q <= acc_init(ST_QROT, 4'd0);
									state_q <= acc_q[AccW-1] ? ST_OUT : ST_QROT;
								end
								ST_QROT: begin
									acc_q <= '0;
									if (have_kf_q) begin
										state_q <= ST_REL;
									end else begin
										for (int i = 0; i < 9; i++)
											rel_q[i] <= (i % 4 == 0) ? RotOne : 16'sd0;
										for (int i = 0; i < 3; i++) tr_q[i] <= '0;
										state_q <= ST_OUT;
									end
								end
								default: state_q <= ST_OUT;
							endcase
						end
					end
				end
				ST_OUT: begin
					if (result.ready) begin
						row_q <= row_q + 2'd1;
						if (!ok_q || row_q == 2'd2) begin
							state_q <= ST_IDLE;
						end
						if (ok_q && row_q == 2'd2) begin
							// The pose becomes the new keyframe.
							have_kf_q <= 1'b1;
							key_stamp_q <= stamp_q;
							for (int i = 0; i < 3; i++) key_pos_q[i] <= pos_q[i];
							key_rot_q <= rc_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Result row from the stored matrix.
	assign result.valid = (state_q == ST_OUT);
	always_comb begin
		result.data = '0;
		result.data.result_id = id_q;
		result.data.last_row = 1'b1;
		if (ok_q) begin
			result.data.accepted = 1'b1;
			result.data.row_index = row_q;
			result.data.rot_col0 = rel_q[idx3(row_q, 2'd0)];
			result.data.rot_col1 = rel_q[idx3(row_q, 2'd1)];
			result.data.rot_col2 = rel_q[idx3(row_q, 2'd2)];
			result.data.trans_part = tr_q[row_q];
			result.data.last_row = (row_q == 2'd2);
		end
	end

endmodule

// ----- design/ksrp_check.sv -----
// Checker: port-level properties of the keyframe selector, bound to the top level.
module ksrp_check (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input ksrp_pkg::row_t out_data
);
	import ksrp_pkg::*;

	// A rejected pose gives a single row zero.
	a_reject_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.accepted |-> out_data.last_row && out_data.row_index == 2'd0)
		else $error("rejected row malformed");

	// No pose is taken while a row is pending.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("pose taken while rows pending");

	// An accepted row that is not the last is followed by the next row.
	a_rows_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_data.last_row |=>
		out_valid && out_data.row_index == $past(out_data.row_index) + 2'd1)
		else $error("row sequence broken");

	// A taken pose produces no row in the cycle after it.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("row too early");

endmodule

bind keyframe_select_relative_pose_core ksrp_check u_ksrp_check (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(pose.valid),
	.in_ready(pose.ready),
	.out_valid(result.valid),
	.out_ready(result.ready),
	.out_data(result.data)
);
